// ===== design/lacz_pkg.sv =====
// ----------------------------------------------------------------------------
// lacz_pkg: shared types and constants for the lagged autocorrelation z-test
// Field widths, queue entry and control structs, back end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lacz_pkg;

    // field and register widths
    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int START_W         = 10;
    localparam int LAG_W           = 7;
    localparam int PICK_W          = 10;
    localparam int SAMPLE_W        = 32;
    localparam int SUM_W           = 48;
    localparam int PAIR_W          = 16;
    localparam int Z_W             = 24;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    // back end arithmetic widths
    localparam int NUM_W       = 52;
    localparam int ROOT_STEPS  = 26;
    localparam int QUOT_W      = 24;
    localparam int MAG_W       = QUOT_W + 1;
    localparam int STEP_W      = 5;
    localparam int TRIPLE_W    = PAIR_W + 2;
    localparam int RADICAND_W  = PAIR_W + 4;

    // saturation limits and band thresholds on the Q16 magnitude
    localparam logic [MAG_W-1:0] MAG_OVER   = MAG_W'(1) << QUOT_W;
    localparam logic [MAG_W-1:0] LIMIT_NEG  = MAG_W'(1) << (Z_W - 1);
    localparam logic [MAG_W-1:0] LIMIT_POS  = LIMIT_NEG - MAG_W'(1);
    localparam int               BAND_LO    = (65536 + 99) / 100;
    localparam int               BAND_HI    = (49 * 65536) / 25;

    localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // register map, selected by paddr[2]
    localparam logic REG_START = 1'b0;
    localparam logic REG_LAG   = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [PAIR_W-1:0] pairs;
    } seq_total_t;

    typedef struct packed {
        logic       push;
        seq_total_t data;
    } q_push_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_SQRT,
        BK_DCHK,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/lacz_queue.sv =====
// ----------------------------------------------------------------------------
// lacz_queue: short queue of finished sequence totals
// Holds sum and pair count of closed sequences until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module lacz_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lacz_pkg::q_push_t   wr,
    input  wire logic                pop,
    output lacz_pkg::seq_total_t     rd_data,
    output lacz_pkg::q_status_t      status
);
    import lacz_pkg::*;

    seq_total_t          mem [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign do_push = wr.push && !status.full;
    assign do_pop  = pop && !status.empty;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr.data;
        end
    end

    assign rd_data      = mem[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(Q_DEPTH));

endmodule

`default_nettype wire

// ===== design/lacz_front.sv =====
// ----------------------------------------------------------------------------
// lacz_front: sample intake, lagged pick and product accumulation
// Picks samples on the lag grid, multiplies neighbors and sums the products.
// ----------------------------------------------------------------------------
`default_nettype none

module lacz_front #(
    parameter int MAX_SAMPLES = lacz_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [lacz_pkg::START_W-1:0]   start_index,
    input  wire logic [lacz_pkg::LAG_W-1:0]     lag,
    input  wire logic [lacz_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                           last,
    input  wire logic                           sample_valid,
    output logic                                sample_ready,
    input  wire lacz_pkg::q_status_t            q_status,
    output lacz_pkg::q_push_t                   q_wr
);
    import lacz_pkg::*;

    localparam int POS_W = $clog2(MAX_SAMPLES + 1);

    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [PICK_W-1:0]     until_reg;
    logic [PICK_W-1:0]     until_next;
    logic [PICK_W-1:0]     until_cur;
    logic [PICK_W-1:0]     lag_m1;
    logic [SAMPLE_W-1:0]   prev_reg;
    logic [SAMPLE_W-1:0]   prev_next;
    logic                  have_reg;
    logic                  have_next;
    logic [PAIR_W-1:0]     pairs_reg;
    logic [PAIR_W-1:0]     pairs_next;
    logic [PAIR_W-1:0]     pairs_cnt;

    logic [2*SAMPLE_W-1:0] prod_full;
    logic [SAMPLE_W-1:0]   prod_reg;
    logic                  prod_v_reg;
    logic                  prod_v_next;
    logic                  s2_last_reg;
    logic                  s2_last_next;
    logic [PAIR_W-1:0]     s2_pairs_reg;

    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [SUM_W-1:0]      sum_new;
    logic [SAMPLE_W-1:0]   prod_add;
    logic [QCNT_W:0]       occupancy;
    logic                  accept;

    // room for a closing beat: queue entries plus one still in the adder stage
    assign occupancy    = {1'b0, q_status.count} + {{QCNT_W{1'b0}}, s2_last_reg};
    assign sample_ready = (occupancy < (QCNT_W + 1)'(Q_DEPTH));
    assign accept       = sample_valid && sample_ready;

    assign until_cur = (pos_reg == '0) ? start_index : until_reg;
    assign lag_m1    = (lag == '0) ? '0 : ({{(PICK_W - LAG_W){1'b0}}, lag} - PICK_W'(1));
    assign prod_full = prev_reg * sample;

    // pick decision and sequence bookkeeping
    always_comb
    begin
        pos_next     = pos_reg;
        until_next   = until_reg;
        prev_next    = prev_reg;
        have_next    = have_reg;
        pairs_cnt    = pairs_reg;
        pairs_next   = pairs_reg;
        prod_v_next  = 1'b0;
        s2_last_next = 1'b0;
        if (accept)
        begin
            if (pos_reg < POS_W'(MAX_SAMPLES))
            begin
                if (until_cur == '0)
                begin
                    if (have_reg)
                    begin
                        prod_v_next = 1'b1;
                        if (pairs_reg != PAIR_MAX)
                        begin
                            pairs_cnt = pairs_reg + PAIR_W'(1);
                        end
                    end
                    prev_next  = sample;
                    have_next  = 1'b1;
                    until_next = lag_m1;
                end
                else
                begin
                    until_next = until_cur - PICK_W'(1);
                end
                pos_next = pos_reg + POS_W'(1);
            end
            pairs_next   = pairs_cnt;
            s2_last_next = last;
            if (last)
            begin
                pos_next   = '0;
                until_next = '0;
                have_next  = 1'b0;
                pairs_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            until_reg   <= '0;
            prev_reg    <= '0;
            have_reg    <= 1'b0;
            pairs_reg   <= '0;
            prod_v_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            until_reg   <= until_next;
            prev_reg    <= prev_next;
            have_reg    <= have_next;
            pairs_reg   <= pairs_next;
            prod_v_reg  <= prod_v_next;
            s2_last_reg <= s2_last_next;
            sum_reg     <= sum_next;
        end
    end

    // product and pair count travel to the adder stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg     <= prod_full[2*SAMPLE_W-1:SAMPLE_W];
            s2_pairs_reg <= pairs_cnt;
        end
    end

    // accumulate, hand the total to the queue on the closing beat
    always_comb
    begin
        prod_add = prod_v_reg ? prod_reg : '0;
        sum_new  = sum_reg + {{(SUM_W - SAMPLE_W){1'b0}}, prod_add};
        sum_next = s2_last_reg ? '0 : sum_new;
    end

    assign q_wr.push       = s2_last_reg;
    assign q_wr.data.sum   = sum_new;
    assign q_wr.data.pairs = s2_pairs_reg;

endmodule

`default_nettype wire

// ===== design/lacz_back.sv =====
// ----------------------------------------------------------------------------
// lacz_back: z statistic from a sequence total
// Numerator, bit-serial square root, restoring division, saturation, band.
// ----------------------------------------------------------------------------
`default_nettype none

module lacz_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lacz_pkg::q_status_t         q_status,
    input  wire lacz_pkg::seq_total_t        q_data,
    output logic                             q_pop,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [lacz_pkg::Z_W-1:0]         z_score,
    output logic                             out_of_band,
    output logic [lacz_pkg::PAIR_W-1:0]      pair_count
);
    import lacz_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [PAIR_W-1:0]   pairs_reg;
    logic [PAIR_W-1:0]   pairs_next;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    num_next;
    logic                neg_reg;
    logic                neg_next;
    logic [NUM_W-1:0]    rad_reg;
    logic [NUM_W-1:0]    rad_next;
    logic [NUM_W-1:0]    root_reg;
    logic [NUM_W-1:0]    root_next;
    logic [NUM_W-1:0]    div_d_reg;
    logic [NUM_W-1:0]    div_d_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [QUOT_W-1:0]   quot_reg;
    logic [QUOT_W-1:0]   quot_next;
    logic                sat_reg;
    logic                sat_next;

    logic                res_valid_reg;
    logic                res_valid_next;
    logic [Z_W-1:0]      z_reg;
    logic [Z_W-1:0]      z_next;
    logic                band_reg;
    logic                band_next;
    logic [PAIR_W-1:0]   pc_reg;
    logic [PAIR_W-1:0]   pc_next;

    logic [NUM_W-1:0]      pos_part;
    logic [NUM_W-1:0]      neg_part;
    logic [TRIPLE_W-1:0]   triple;
    logic [RADICAND_W-1:0] radicand;
    logic [NUM_W-1:0]      bit_val;
    logic [NUM_W-1:0]      trial;
    logic [NUM_W-1:0]      den_top;
    logic [MAG_W-1:0]      mag_raw;
    logic [MAG_W-1:0]      limit;
    logic [MAG_W-1:0]      mag;
    logic [MAG_W-1:0]      mag_neg;
    logic                  slot_free;

    // 12*sum and 3*pairs in Q32
    assign pos_part = {1'b0, sum_reg, 3'b000} + {2'b00, sum_reg, 2'b00};
    assign triple   = {1'b0, pairs_reg, 1'b0} + {2'b00, pairs_reg};
    assign neg_part = {{(NUM_W - TRIPLE_W - 32){1'b0}}, triple, 32'h0};

    // 13*pairs - 6
    assign radicand = {1'b0, pairs_reg, 3'b000} + {2'b00, pairs_reg, 2'b00}
                    + {4'b0000, pairs_reg} - RADICAND_W'(6);

    // square root step: one result bit per cycle
    assign bit_val = NUM_W'(1) << {step_reg, 1'b0};
    assign trial   = root_reg + bit_val;

    // quotient overflow bound: divisor shifted by the quotient width
    assign den_top = {root_reg[NUM_W-QUOT_W-1:0], {QUOT_W{1'b0}}};

    // saturation and sign
    assign mag_raw = sat_reg ? MAG_OVER : {1'b0, quot_reg};
    assign limit   = neg_reg ? LIMIT_NEG : LIMIT_POS;
    assign mag     = (mag_raw > limit) ? limit : mag_raw;
    assign mag_neg = MAG_OVER - mag;

    assign slot_free = !res_valid_reg || result_ready;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        pairs_next     = pairs_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        div_d_next     = div_d_reg;
        step_next      = step_reg;
        quot_next      = quot_reg;
        sat_next       = sat_reg;
        z_next         = z_reg;
        band_next      = band_reg;
        pc_next        = pc_reg;
        res_valid_next = res_valid_reg && !result_ready;
        q_pop          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    sum_next   = q_data.sum;
                    pairs_next = q_data.pairs;
                    state_next = BK_PREP;
                end
            end
            BK_PREP:
            begin
                quot_next = '0;
                sat_next  = 1'b0;
                if (pairs_reg == '0)
                begin
                    neg_next   = 1'b0;
                    state_next = BK_DONE;
                end
                else
                begin
                    neg_next   = (neg_part > pos_part);
                    num_next   = (neg_part > pos_part) ? (neg_part - pos_part)
                                                       : (pos_part - neg_part);
                    rad_next   = {radicand, 32'h0};
                    root_next  = '0;
                    step_next  = STEP_W'(ROOT_STEPS - 1);
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT:
            begin
                if (rad_reg >= trial)
                begin
                    rad_next  = rad_reg - trial;
                    root_next = (root_reg >> 1) + bit_val;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = BK_DCHK;
                end
            end
            BK_DCHK:
            begin
                div_d_next = root_reg << (QUOT_W - 1);
                step_next  = STEP_W'(QUOT_W - 1);
                if (num_reg >= den_top)
                begin
                    sat_next   = 1'b1;
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (num_reg >= div_d_reg)
                begin
                    num_next  = num_reg - div_d_reg;
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                div_d_next = div_d_reg >> 1;
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    z_next         = neg_reg ? mag_neg[Z_W-1:0] : mag[Z_W-1:0];
                    band_next      = (mag < MAG_W'(BAND_LO)) || (mag > MAG_W'(BAND_HI));
                    pc_next        = pairs_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            step_reg      <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        pairs_reg <= pairs_next;
        num_reg   <= num_next;
        neg_reg   <= neg_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        div_d_reg <= div_d_next;
        quot_reg  <= quot_next;
        sat_reg   <= sat_next;
        z_reg     <= z_next;
        band_reg  <= band_next;
        pc_reg    <= pc_next;
    end

    assign result_valid = res_valid_reg;
    assign z_score      = z_reg;
    assign out_of_band  = band_reg;
    assign pair_count   = pc_reg;

endmodule

`default_nettype wire

// ===== design/lagged_autocorrelation_z_test.sv =====
// ----------------------------------------------------------------------------
// lagged_autocorrelation_z_test: lag-m autocorrelation z-test on a sample stream
// Samples enter with a last flag; one z result leaves per closed sequence.
// ----------------------------------------------------------------------------
// Usage
//   sample channel: sample, last, sample_valid / sample_ready. One beat per
//   cycle; sample_ready drops only while two closed sequences wait for the
//   back end. The sample flagged last closes a sequence.
//   result channel: z_score (Q7.16), out_of_band, pair_count with
//   result_valid / result_ready; one beat per closed sequence.
//   APB port: start_index at 0x0, lag at 0x4, written while idle.
// Flow
//   front end takes a sample every cycle while sample_ready is high; a closed
//   total is queued in the cycle after its closing beat. back end: one sequence
//   at a time (pop, numerator, bit-serial root, overflow check, divide, load;
//   no divide when saturated, neither root nor divide without pairs).
// Reset and stall
//   reset clears sequence state, queue and result; start_index 0, lag 1.
//   A stalled result holds in its output register; samples flow until full.
// ----------------------------------------------------------------------------
`default_nettype none

module lagged_autocorrelation_z_test #(
    parameter int MAX_SAMPLES = lacz_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // apb configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lacz_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lacz_pkg::APB_DW-1:0]    pwdata,
    output logic [lacz_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    // sample channel
    input  wire logic [lacz_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                           last,
    input  wire logic                           sample_valid,
    output logic                                sample_ready,
    // result channel
    output logic [lacz_pkg::Z_W-1:0]            z_score,
    output logic                                out_of_band,
    output logic [lacz_pkg::PAIR_W-1:0]         pair_count,
    output logic                                result_valid,
    input  wire logic                           result_ready
);
    import lacz_pkg::*;

    logic [START_W-1:0] start_reg;
    logic [LAG_W-1:0]   lag_reg;
    logic               cfg_wr;
    q_push_t            q_wr;
    q_status_t          q_status;
    seq_total_t         q_data;
    logic               q_pop;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            lag_reg   <= LAG_W'(1);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_START)
            begin
                start_reg <= pwdata[START_W-1:0];
            end
            else
            begin
                lag_reg <= pwdata[LAG_W-1:0];
            end
        end
    end

    // register readback
    always_comb
    begin
        if (paddr[2] == REG_LAG)
        begin
            prdata = {{(APB_DW - LAG_W){1'b0}}, lag_reg};
        end
        else
        begin
            prdata = {{(APB_DW - START_W){1'b0}}, start_reg};
        end
    end

    lacz_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_index  (start_reg),
        .lag          (lag_reg),
        .sample       (sample),
        .last         (last),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .q_status     (q_status),
        .q_wr         (q_wr)
    );

    lacz_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .pop     (q_pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    lacz_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .z_score      (z_score),
        .out_of_band  (out_of_band),
        .pair_count   (pair_count)
    );

`ifndef SYNTHESIS
    // a closed total never arrives at a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr.push && q_status.full))
        else $error("sequence total pushed into full queue");

    // the back end only pops a queue that holds an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // no pairs means a zero statistic flagged out of band
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (pair_count == '0)) |-> ((z_score == '0) && out_of_band))
        else $error("empty sequence gave nonzero z");

    // an in-band result is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !out_of_band) |-> (z_score != '0))
        else $error("zero z reported in band");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: lagged autocorrelation z-test bench
// Drives sample sequences through the valid/ready sample channel, programs
// start_index and lag over APB while idle, and checks each z result against
// a behavioral predictor. Phases vary the register settings and the amount
// of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;

    import lacz_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int SAMPLE_CAP    = MAX_SAMPLES_DEF;
    localparam int PLAN_ROWS     = 25;
    localparam int PHASE_COUNT   = 7;

    typedef struct packed {
        logic [Z_W-1:0]    z;
        logic              band;
        logic [PAIR_W-1:0] pairs;
    } z_result_t;

    // one row of the directed plan; registers are written before the row when set_cfg is set
    typedef struct packed {
        bit                  set_cfg;
        logic [START_W-1:0]  start;
        logic [LAG_W-1:0]    lag;
        logic [SAMPLE_W-1:0] value;
        logic                fin;
        bit                  typed;
        z_result_t           want;
    } plan_row_t;

    typedef struct packed {
        int unsigned start;
        int unsigned lag;
        int unsigned seqs;
        int unsigned send_pct;
        int unsigned stall_pct;
    } phase_t;

    typedef enum int {
        FILL_UNIFORM,
        FILL_HIGH,
        FILL_LOW,
        FILL_EDGES
    } fill_t;

    localparam z_result_t NO_PAIRS = '{z: '0, band: 1'b1, pairs: '0};
    localparam z_result_t UNTYPED  = '0;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // defaults after reset: single sample, no pairs
        '{1'b0, 10'd0,    7'd0,   32'h1234_5678, 1'b1, 1'b1, NO_PAIRS},
        '{1'b0, 10'd0,    7'd0,   32'h0000_0000, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h0000_0000, 1'b1, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hFFFF_FFFF, 1'b1, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h0000_0000, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h8000_0000, 1'b1, 1'b0, UNTYPED},
        // start index at the register maximum, lag of zero
        '{1'b1, 10'd1023, 7'd0,   32'hDEAD_BEEF, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h2152_4110, 1'b1, 1'b1, NO_PAIRS},
        // lag of zero behaves as lag one
        '{1'b1, 10'd0,    7'd0,   32'h8000_0000, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h8000_0001, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h7FFF_FFFF, 1'b1, 1'b0, UNTYPED},
        // lag of 100: only one pick in a short sequence
        '{1'b1, 10'd2,    7'd100, 32'h0000_0001, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hFFFF_FFFE, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hC000_0000, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h4000_0000, 1'b1, 1'b1, NO_PAIRS},
        // lag two from position one
        '{1'b1, 10'd1,    7'd2,   32'h1111_1111, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hEEEE_EEEE, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h3333_3333, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hCCCC_CCCC, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'h0F0F_0F0F, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hF0F0_F0F0, 1'b1, 1'b0, UNTYPED},
        // back to defaults
        '{1'b1, 10'd0,    7'd1,   32'h5555_5555, 1'b0, 1'b0, UNTYPED},
        '{1'b0, 10'd0,    7'd0,   32'hAAAA_AAAA, 1'b1, 1'b0, UNTYPED}
    };

    localparam phase_t PHASES [PHASE_COUNT] = '{
        '{0,  1,  10, 0,  0},
        '{3,  2,  7,  46, 0},
        '{0,  0,  10, 0,  46},
        '{5,  7,  3,  37, 37},
        '{40, 3,  1,  0,  0},
        '{2,  1,  6,  46, 0},
        '{0,  12, 1,  0,  46}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                sample_valid;
    logic                sample_ready;
    logic [Z_W-1:0]      z_score;
    logic                out_of_band;
    logic [PAIR_W-1:0]   pair_count;
    logic                result_valid;
    logic                result_ready;

    // predictor copy of registers and sequence state
    logic [START_W-1:0]  cfg_start;
    logic [LAG_W-1:0]    cfg_lag;
    int unsigned         seq_pos;
    int unsigned         pick_countdown;
    logic [SAMPLE_W-1:0] prev_pick;
    bit                  have_prev;
    logic [SUM_W-1:0]    corr_sum;
    logic [PAIR_W-1:0]   pair_total;

    z_result_t   pending_z[$];
    int          error_count;
    int          cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    lagged_autocorrelation_z_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample       (sample),
        .last         (last),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .z_score      (z_score),
        .out_of_band  (out_of_band),
        .pair_count   (pair_count),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always #6 clk = ~clk;

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // floor of the square root, bit by bit
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned acc;
        longint unsigned probe;
        acc   = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= acc + probe)
            begin
                v   = v - (acc + probe);
                acc = (acc >> 1) + probe;
            end
            else
                acc = acc >> 1;
            probe = probe >> 2;
        end
        return acc;
    endfunction

    // z statistic from the pair sum of the closed sequence
    function automatic z_result_t z_of_sequence(input logic [SUM_W-1:0] sum,
                                                input logic [PAIR_W-1:0] pairs);
        z_result_t       res;
        longint unsigned pos_part;
        longint unsigned neg_part;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        bit              neg;
        res = NO_PAIRS;
        if (pairs != 0)
        begin
            pos_part = 64'(sum) * 64'd12;
            neg_part = (64'(pairs) * 64'd3) << 32;
            neg      = neg_part > pos_part;
            num      = neg ? neg_part - pos_part : pos_part - neg_part;
            den      = root_floor((64'(pairs) * 64'd13 - 64'd6) << 32);
            mag      = num / den;
            if (neg && mag > 64'd8388608)
                mag = 64'd8388608;
            else if (!neg && mag > 64'd8388607)
                mag = 64'd8388607;
            res.band = (mag * 100 < 65536) || (mag * 25 > 49 * 65536);
            res.z    = neg ? -Z_W'(mag) : Z_W'(mag);
        end
        res.pairs = pairs;
        return res;
    endfunction

    // advance the sequence state by one sample beat
    task automatic take_sample(input logic [SAMPLE_W-1:0] x, input logic fin,
                               output bit got, output z_result_t res);
        longint unsigned prod;
        got = 1'b0;
        res = UNTYPED;
        if (seq_pos < SAMPLE_CAP)
        begin
            if (seq_pos == 0)
                pick_countdown = cfg_start;
            if (pick_countdown == 0)
            begin
                if (have_prev)
                begin
                    prod     = (64'(prev_pick) * 64'(x)) >> 32;
                    corr_sum = corr_sum + SUM_W'(prod);
                    if (pair_total != PAIR_MAX)
                        pair_total = pair_total + 1'b1;
                end
                prev_pick      = x;
                have_prev      = 1'b1;
                pick_countdown = (cfg_lag == 0) ? 0 : cfg_lag - 1;
            end
            else
                pick_countdown = pick_countdown - 1;
            seq_pos = seq_pos + 1;
        end
        if (fin)
        begin
            got            = 1'b1;
            res            = z_of_sequence(corr_sum, pair_total);
            seq_pos        = 0;
            pick_countdown = 0;
            prev_pick      = '0;
            have_prev      = 1'b0;
            corr_sum       = '0;
            pair_total     = '0;
        end
    endtask

    // result beat check
    always @(posedge clk)
    begin
        z_result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_z.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: z %h band %b pairs %0d",
                         $time, z_score, out_of_band, pair_count);
                error_count = error_count + 1;
            end
            else
            begin
                exp_r = pending_z.pop_front();
                if (z_score !== exp_r.z)
                begin
                    $display("%0t: z_score expected %h actual %h", $time, exp_r.z, z_score);
                    error_count = error_count + 1;
                end
                if (out_of_band !== exp_r.band)
                begin
                    $display("%0t: out_of_band expected %b actual %b",
                             $time, exp_r.band, out_of_band);
                    error_count = error_count + 1;
                end
                if (pair_count !== exp_r.pairs)
                begin
                    $display("%0t: pair_count expected %0d actual %0d",
                             $time, exp_r.pairs, pair_count);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // one sample beat, called and returning at a falling edge
    task automatic send_beat(input logic [SAMPLE_W-1:0] x, input logic fin,
                             input bit typed, input z_result_t want);
        bit        got;
        z_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample       <= x;
        last         <= fin;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        take_sample(x, fin, got, res);
        if (got)
            pending_z.push_back(typed ? want : res);
        @(negedge clk);
    endtask

    // drain all results, then let the back end settle
    task automatic wait_idle();
        while (pending_z.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // apb write: setup then access, then the bus returns to idle
    task automatic write_reg(input logic sel, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == REG_START)
            cfg_start = START_W'(value);
        else
            cfg_lag = LAG_W'(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] fill_value(input fill_t fill);
        logic [SAMPLE_W-1:0] v;
        v = $urandom;
        case (fill)
            FILL_HIGH: v = v | 32'hE000_0000;
            FILL_LOW:  v = v >> $urandom_range(3, 31);
            FILL_EDGES:
            begin
                case ($urandom_range(0, 2))
                    0: v = '0;
                    1: v = '1;
                    default: v = v;
                endcase
            end
            default: v = v;
        endcase
        return v;
    endfunction

    // random sequences shaped to the register settings
    task automatic run_phase(input int unsigned start, input int unsigned lag,
                             input int unsigned seqs, input int unsigned send_pct,
                             input int unsigned stall_pct);
        int unsigned eff_lag;
        int unsigned len;
        fill_t       fill;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        write_reg(REG_START, start);
        write_reg(REG_LAG, lag);
        eff_lag = (lag == 0) ? 1 : lag;
        for (int s = 0; s < seqs; s++)
        begin
            // mostly sequences long enough for several picks, some stubs
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, 3);
            else
                len = start + eff_lag * $urandom_range(0, 8) + $urandom_range(1, eff_lag);
            fill = fill_t'($urandom_range(0, 3));
            for (int n = 0; n < len; n++)
                send_beat(fill_value(fill), n == len - 1, 1'b0, UNTYPED);
        end
        sample_valid <= 1'b0;
        wait_idle();
    endtask

    initial
    begin
        plan_row_t row;
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sample         = '0;
        last           = 1'b0;
        sample_valid   = 1'b0;
        result_ready   = 1'b0;
        cfg_start      = '0;
        cfg_lag        = LAG_W'(1);
        seq_pos        = 0;
        pick_countdown = 0;
        prev_pick      = '0;
        have_prev      = 1'b0;
        corr_sum       = '0;
        pair_total     = '0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed plan
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            row = PLAN[i];
            if (row.set_cfg)
            begin
                sample_valid <= 1'b0;
                wait_idle();
                write_reg(REG_START, row.start);
                write_reg(REG_LAG, row.lag);
            end
            send_beat(row.value, row.fin, row.typed, row.want);
        end
        sample_valid <= 1'b0;
        wait_idle();

        // random phases
        for (int p = 0; p < PHASE_COUNT; p++)
            run_phase(PHASES[p].start, PHASES[p].lag, PHASES[p].seqs,
                      PHASES[p].send_pct, PHASES[p].stall_pct);
        run_phase($urandom_range(0, 20), $urandom_range(1, 10), 3, 37, 37);
        run_phase($urandom_range(0, 6), $urandom_range(1, 4), 6, 0, 0);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/lacz_pkg.sv
design/lacz_queue.sv
design/lacz_front.sv
design/lacz_back.sv
design/lagged_autocorrelation_z_test.sv
bench/testbench.sv
